// ===== rtl/min_rate_binary_search_unit_assert.svh =====
// Assertion macros shared by the minimum rate search unit.
`ifndef MIN_RATE_BINARY_SEARCH_UNIT_ASSERT_SVH
`define MIN_RATE_BINARY_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MRBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("min rate search: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MRBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("min rate search: next-cycle check failed");

`endif

// ===== rtl/mrbs_pkg.sv =====
// Package with sizes, types and sequencer states of the minimum rate search unit.
package mrbs_pkg;

  // Store depth and derived widths.
  localparam int unsigned MAX_JOBS = 1024;
  localparam int unsigned SIZE_W   = 31;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int unsigned ADDR_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned SUM_W    = SIZE_W + CNT_W;
  localparam int unsigned STEP_W   = $clog2(SIZE_W);
  localparam int unsigned IN_TDATA_W  = ((SIZE_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((SIZE_W + 7) / 8) * 8;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MID,
    S_READ,
    S_LOAD,
    S_WAIT,
    S_CHECK,
    S_DONE
  } seq_state_t;

  // Request to the ceiling divider.
  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  // Answer of the ceiling divider.
  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] quot;
  } div_res_t;

endpackage

// ===== rtl/min_rate_binary_search_unit.sv =====
// Minimum rate search: job sizes are stored, then rates are binary searched.
// Non-final jobs are accepted back to back while idle; no word is accepted while a search runs.
// A search takes about 31 rounds; each round divides every stored job by the middle rate.
// The bit-serial divider gives one quotient bit per cycle, and the sequencer waits for each division.
// Reset clears the job count, largest size and output valid; budget returns to 1.
// Store contents are not cleared; only entries below the job count are read.
`include "min_rate_binary_search_unit_assert.svh"

module min_rate_binary_search_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration channel: slot budget.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrbs_pkg::CFG_W-1:0]          cfg_data,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mrbs_pkg::IN_TDATA_W-1:0]     s_tdata,   // [30:0] job_size, [31] zero
  input  logic                                s_tlast,   // last_job
  // Result stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mrbs_pkg::OUT_TDATA_W-1:0]    m_tdata    // [30:0] min_rate, [31] zero
);
  import mrbs_pkg::*;

  seq_state_t        state;
  seq_state_t        state_next;
  logic [CFG_W-1:0]  slot_budget;
  logic [CNT_W-1:0]  job_count;
  logic [SIZE_W-1:0] largest_job;
  logic [SIZE_W-1:0] largest_next;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_inc;
  logic [31:0]       lo;
  logic [SIZE_W-1:0] hi;
  logic [SIZE_W-1:0] mid;
  logic [SIZE_W-1:0] best;
  logic [SUM_W-1:0]  sum;
  logic [31:0]       span;
  logic              range_open;
  logic              budget_met;
  logic              in_acc;
  logic              store_free;
  logic              out_free;
  logic [SIZE_W-1:0] job_size;
  logic [SIZE_W-1:0] rd_data;
  logic              rd_en;
  div_req_t          div_req;
  div_res_t          div_res;

  assign cfg_ready  = 1'b1;
  assign s_tready   = (state == S_IDLE);
  assign job_size   = s_tdata[SIZE_W-1:0];
  assign in_acc     = s_tvalid && s_tready;
  assign store_free = job_count < CNT_W'(MAX_JOBS);
  assign out_free   = !m_tvalid || m_tready;
  assign idx_inc    = idx + 1'b1;

  // Search arithmetic.
  always_comb begin
    largest_next = largest_job;
    if (store_free && (job_size > largest_job)) begin
      largest_next = job_size;
    end
    range_open = lo <= {1'b0, hi};
    span       = {1'b0, hi} - lo;
    budget_met = sum <= SUM_W'(slot_budget);
  end

  // Job store.
  mrbs_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (MAX_JOBS)
  ) u_store (
    .clk   (clk),
    .we    (in_acc && store_free),
    .waddr (job_count[ADDR_W-1:0]),
    .wdata (job_size),
    .re    (rd_en),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // Ceiling divider shared by all jobs and rounds.
  mrbs_ceil_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_next       = state;
    rd_en            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = rd_data;
    div_req.divisor  = mid;
    case (state)
      S_IDLE: begin
        if (in_acc && s_tlast) begin
          state_next = S_MID;
        end
      end
      S_MID: begin
        state_next = range_open ? S_READ : S_DONE;
      end
      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        div_req.start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (div_res.done) begin
          state_next = (idx_inc == job_count) ? S_CHECK : S_READ;
        end
      end
      S_CHECK: begin
        state_next = S_MID;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_budget <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      slot_budget <= cfg_data;
    end
  end

  // Set bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_count   <= '0;
      largest_job <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid    <= 1'b1;
        job_count   <= '0;
        largest_job <= '0;
      end else begin
        if (m_tvalid && m_tready) begin
          m_tvalid <= 1'b0;
        end
        if (in_acc) begin
          largest_job <= largest_next;
          if (store_free) begin
            job_count <= job_count + 1'b1;
          end
        end
      end
    end
  end

  // Search datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        lo   <= 32'd1;
        hi   <= largest_next;
        best <= '0;
      end
      S_MID: begin
        mid <= SIZE_W'(lo + (span >> 1));
        sum <= '0;
        idx <= '0;
      end
      S_WAIT: begin
        if (div_res.done) begin
          sum <= sum + SUM_W'(div_res.quot);
          idx <= idx_inc;
        end
      end
      S_CHECK: begin
        if (budget_met) begin
          best <= mid;
          hi   <= mid - 1'b1;
        end else begin
          lo   <= {1'b0, mid} + 32'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          m_tdata <= OUT_TDATA_W'(best);
        end
      end
      default: begin
      end
    endcase
  end

  // Checks on the sequencer.
  `MRBS_ASSERT_NOW(a_count_bound, 1'b1, job_count <= CNT_W'(MAX_JOBS))
  `MRBS_ASSERT_NOW(a_all_jobs_summed, state == S_CHECK, idx == job_count)
  `MRBS_ASSERT_NEXT(a_result_clears_set, state == S_DONE && out_free,
                    m_tvalid && job_count == '0 && state == S_IDLE)
  `MRBS_ASSERT_NOW(a_search_has_jobs, state == S_READ, job_count != '0)

endmodule

// ===== rtl/mrbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mrbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mrbs_ceil_div.sv =====
// Bit-serial restoring divider that returns the ceiling of a quotient.
module mrbs_ceil_div (
  input  logic               clk,
  input  logic               rst,
  input  mrbs_pkg::div_req_t req,
  output mrbs_pkg::div_res_t res
);
  import mrbs_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [SIZE_W-1:0] dvd;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] dsr;
  logic [SIZE_W:0]   shifted;
  logic [SIZE_W:0]   diff;
  logic              fits;

  // One quotient bit per cycle while busy: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem, dvd[SIZE_W-1]};
    diff    = shifted - {1'b0, dsr};
    fits    = shifted >= {1'b0, dsr};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SIZE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  // Dividend becomes the quotient as it shifts out; remainder builds up beside it.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      dvd <= {dvd[SIZE_W-2:0], fits};
      rem <= fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
    end
  end

  // Round up when anything is left over.
  always_comb begin
    res.done = done;
    res.quot = dvd + SIZE_W'(rem != '0);
  end

endmodule
